// ----- rtl/mesd_pkg.sv -----
// ============================================================================
// mesd_pkg
// Shared types, codes and helpers of the music event stream decoder.
// ============================================================================
`default_nettype none

package mesd_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int CH_BITS       = $clog2(CHANNEL_COUNT);
    localparam int DELAY_BITS    = 28;
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASTER_VOLUME = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_ENABLE   = 2'd1;
    localparam logic [6:0] MASTER_VOLUME_RESET = 7'd127;

    // result kinds
    localparam logic [3:0] KIND_KEY_OFF   = 4'd0;
    localparam logic [3:0] KIND_KEY_ON    = 4'd1;
    localparam logic [3:0] KIND_BEND      = 4'd2;
    localparam logic [3:0] KIND_CTRL      = 4'd3;
    localparam logic [3:0] KIND_PROGRAM   = 4'd4;
    localparam logic [3:0] KIND_NOTES_OFF = 4'd5;
    localparam logic [3:0] KIND_LOOP      = 4'd6;
    localparam logic [3:0] KIND_STOP      = 4'd7;
    localparam logic [3:0] KIND_DELAY     = 4'd8;

    // event types in the event byte
    localparam logic [2:0] TYPE_KEY_OFF   = 3'd0;
    localparam logic [2:0] TYPE_KEY_ON    = 3'd1;
    localparam logic [2:0] TYPE_BEND      = 3'd2;
    localparam logic [2:0] TYPE_SYS_CTRL  = 3'd3;
    localparam logic [2:0] TYPE_CTRL      = 3'd4;
    localparam logic [2:0] TYPE_SCORE_END = 3'd6;

    // parse phases
    localparam logic [3:0] PH_EVENT    = 4'd0;
    localparam logic [3:0] PH_KEY_OFF  = 4'd1;
    localparam logic [3:0] PH_KEY_ON   = 4'd2;
    localparam logic [3:0] PH_VELOCITY = 4'd3;
    localparam logic [3:0] PH_BEND     = 4'd4;
    localparam logic [3:0] PH_SYS_CTRL = 4'd5;
    localparam logic [3:0] PH_CTRL_NUM = 4'd6;
    localparam logic [3:0] PH_CTRL_VAL = 4'd7;
    localparam logic [3:0] PH_DELAY    = 4'd8;

    // controller numbers
    localparam logic [7:0] CTRL_PROGRAM    = 8'd0;
    localparam logic [7:0] CTRL_VOLUME     = 8'd3;
    localparam logic [7:0] CTRL_PAN        = 8'd4;
    localparam logic [7:0] CTRL_NOTES_OFF  = 8'd10;
    localparam logic [7:0] CTRL_SOUND_OFF  = 8'd11;
    localparam logic [7:0] CTRL_RESTORE    = 8'd14;

    typedef struct packed {
        logic [3:0]            kind;
        logic [CH_BITS-1:0]    channel;
        logic [7:0]            number;
        logic [7:0]            value;
        logic [DELAY_BITS-1:0] ticks;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(
        input logic [3:0]            kind,
        input logic [CH_BITS-1:0]    channel,
        input logic [7:0]            number,
        input logic [7:0]            value,
        input logic [DELAY_BITS-1:0] ticks,
        input logic                  last
    );
        result_t r;
        r.kind    = kind;
        r.channel = channel;
        r.number  = number;
        r.value   = value;
        r.ticks   = ticks;
        r.last    = last;
        return r;
    endfunction

    function automatic logic [7:0] clamp_volume(
        input logic [7:0] v,
        input logic [6:0] master,
        input logic [6:0] fade
    );
        logic [7:0] c;
        c = v;
        if (c > {1'b0, master})
        begin
            c = {1'b0, master};
        end
        if (c > {1'b0, fade})
        begin
            c = {1'b0, fade};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mesd_parser.sv -----
// ============================================================================
// mesd_parser
// Parse state, per-channel velocity table and single-pass byte decode.
// ============================================================================
`default_nettype none

module mesd_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  go,
    input  wire logic [7:0]            byte_in,
    input  wire logic [6:0]            fade,
    input  wire logic [6:0]            master,
    input  wire logic                  loop_en,
    output mesd_pkg::push_t            push
);
    import mesd_pkg::*;

    logic [3:0]            phase_reg, phase_next;
    logic [CH_BITS-1:0]    chan_reg, chan_next;
    logic [7:0]            num_reg, num_next;
    logic                  follows_reg, follows_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic                  stopped_reg, stopped_next;
    logic [7:0]            vel_reg [CHANNEL_COUNT];
    logic                  vel_we;
    logic [7:0]            vel_rd;
    logic [DELAY_BITS+7:0] delay_sum;
    logic [DELAY_BITS-1:0] delay_sat;
    logic [DELAY_BITS-1:0] zero_ticks;
    push_t                 push_c;

    assign vel_rd     = vel_reg[chan_reg];
    assign zero_ticks = '0;

    always_comb
    begin
        delay_sum = {1'b0, delay_reg, 7'b0} + {(DELAY_BITS + 1)'(0), byte_in[6:0]};
        if (delay_sum[DELAY_BITS+7:DELAY_BITS] != '0)
        begin
            delay_sat = DELAY_MAX;
        end
        else
        begin
            delay_sat = delay_sum[DELAY_BITS-1:0];
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        chan_next    = chan_reg;
        num_next     = num_reg;
        follows_next = follows_reg;
        delay_next   = delay_reg;
        stopped_next = stopped_reg;
        vel_we       = 1'b0;
        push_c       = '0;
        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_EVENT:
                begin
                    chan_next    = byte_in[CH_BITS-1:0];
                    follows_next = byte_in[7];
                    case (byte_in[6:4])
                        TYPE_KEY_OFF:  phase_next = PH_KEY_OFF;
                        TYPE_KEY_ON:   phase_next = PH_KEY_ON;
                        TYPE_BEND:     phase_next = PH_BEND;
                        TYPE_SYS_CTRL: phase_next = PH_SYS_CTRL;
                        TYPE_CTRL:     phase_next = PH_CTRL_NUM;
                        TYPE_SCORE_END:
                        begin
                            push_c.count = 2'd1;
                            if (loop_en)
                            begin
                                push_c.first = make_result(KIND_LOOP, byte_in[CH_BITS-1:0],
                                                           8'd0, 8'd0, zero_ticks, 1'b1);
                                delay_next   = '0;
                                phase_next   = byte_in[7] ? PH_DELAY : PH_EVENT;
                            end
                            else
                            begin
                                push_c.first = make_result(KIND_STOP, byte_in[CH_BITS-1:0],
                                                           8'd0, 8'd0, zero_ticks, 1'b1);
                                stopped_next = 1'b1;
                                phase_next   = PH_EVENT;
                            end
                        end
                        default:
                        begin
                            delay_next = '0;
                            phase_next = byte_in[7] ? PH_DELAY : PH_EVENT;
                        end
                    endcase
                end
                PH_KEY_ON:
                begin
                    if (byte_in[7])
                    begin
                        num_next   = {1'b0, byte_in[6:0]};
                        phase_next = PH_VELOCITY;
                    end
                    else
                    begin
                        push_c.count = 2'd1;
                        push_c.first = make_result(KIND_KEY_ON, chan_reg, byte_in, vel_rd,
                                                   zero_ticks, 1'b1);
                    end
                end
                PH_CTRL_NUM:
                begin
                    num_next   = byte_in;
                    phase_next = PH_CTRL_VAL;
                end
                PH_DELAY:
                begin
                    delay_next = delay_sat;
                    if (!byte_in[7])
                    begin
                        push_c.count = 2'd1;
                        push_c.first = make_result(KIND_DELAY, '0, 8'd0, 8'd0,
                                                   delay_sat, 1'b1);
                        phase_next   = PH_EVENT;
                    end
                end
                PH_KEY_OFF:
                begin
                    push_c.count = 2'd1;
                    push_c.first = make_result(KIND_KEY_OFF, chan_reg, {1'b0, byte_in[6:0]},
                                               8'd0, zero_ticks, 1'b1);
                end
                PH_VELOCITY:
                begin
                    vel_we       = 1'b1;
                    push_c.count = 2'd1;
                    push_c.first = make_result(KIND_KEY_ON, chan_reg, num_reg, byte_in,
                                               zero_ticks, 1'b1);
                end
                PH_BEND:
                begin
                    push_c.count = 2'd1;
                    push_c.first = make_result(KIND_BEND, chan_reg, 8'd0, byte_in,
                                               zero_ticks, 1'b1);
                end
                PH_SYS_CTRL:
                begin
                    push_c.count = 2'd1;
                    push_c.first = make_result(KIND_CTRL, chan_reg, byte_in, 8'd0,
                                               zero_ticks, 1'b1);
                end
                PH_CTRL_VAL:
                begin
                    case (num_reg)
                        CTRL_PROGRAM:
                        begin
                            push_c.count = 2'd1;
                            push_c.first = make_result(KIND_PROGRAM, chan_reg, byte_in, 8'd0,
                                                       zero_ticks, 1'b1);
                        end
                        CTRL_VOLUME:
                        begin
                            push_c.count = 2'd1;
                            push_c.first = make_result(KIND_CTRL, chan_reg, CTRL_VOLUME,
                                                       clamp_volume(byte_in, master, fade),
                                                       zero_ticks, 1'b1);
                        end
                        CTRL_PAN:
                        begin
                            push_c.count = 2'd1;
                            push_c.first = make_result(KIND_CTRL, chan_reg, CTRL_PAN, byte_in,
                                                       zero_ticks, 1'b1);
                        end
                        CTRL_NOTES_OFF, CTRL_SOUND_OFF:
                        begin
                            push_c.count = 2'd1;
                            push_c.first = make_result(KIND_NOTES_OFF, chan_reg, num_reg,
                                                       byte_in, zero_ticks, 1'b1);
                        end
                        CTRL_RESTORE:
                        begin
                            push_c.count  = 2'd2;
                            push_c.first  = make_result(KIND_NOTES_OFF, chan_reg, CTRL_RESTORE,
                                                        byte_in, zero_ticks, 1'b0);
                            push_c.second = make_result(KIND_CTRL, chan_reg, CTRL_VOLUME,
                                                        clamp_volume(vel_rd, master, fade),
                                                        zero_ticks, 1'b1);
                        end
                        default:
                        begin
                            push_c.count = 2'd0;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_EVENT;
                end
            endcase
            // payload phases finish the event
            if (phase_reg == PH_KEY_OFF || phase_reg == PH_VELOCITY || phase_reg == PH_BEND
                || phase_reg == PH_SYS_CTRL || phase_reg == PH_CTRL_VAL
                || (phase_reg == PH_KEY_ON && !byte_in[7]))
            begin
                delay_next = '0;
                phase_next = follows_reg ? PH_DELAY : PH_EVENT;
            end
        end
    end

    assign push.count  = go ? push_c.count : 2'd0;
    assign push.first  = push_c.first;
    assign push.second = push_c.second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_EVENT;
            chan_reg    <= '0;
            num_reg     <= '0;
            follows_reg <= 1'b0;
            delay_reg   <= '0;
            stopped_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                vel_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            chan_reg    <= chan_next;
            num_reg     <= num_next;
            follows_reg <= follows_next;
            delay_reg   <= delay_next;
            stopped_reg <= stopped_next;
            if (vel_we)
            begin
                vel_reg[chan_reg] <= byte_in;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mesd_result_queue.sv -----
// ============================================================================
// mesd_result_queue
// Small result queue taking up to two words per cycle, one out per cycle while not stalled.
// ============================================================================
`default_nettype none

module mesd_result_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mesd_pkg::push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output mesd_pkg::result_t    head
);
    import mesd_pkg::*;

    result_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_BITS-1:0]  head_reg, tail_reg;
    logic [QUEUE_BITS:0]    count_reg, count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[head_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= (QUEUE_BITS + 1)'(QUEUE_DEPTH - 2));

    always_comb
    begin
        count_next = count_reg + (QUEUE_BITS + 1)'(push.count)
                     - (QUEUE_BITS + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            tail_reg  <= tail_reg + QUEUE_BITS'(push.count);
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_reg + 1'b1] <= push.second;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mus_event_stream_decoder_core.sv -----
// ============================================================================
// mus_event_stream_decoder_core
// Music score byte stream decoder: events, payloads and variable delays.
// ============================================================================
// Takes one score byte per cycle while not stalled. A byte is held in the input
// register, is decoded against the parse state in a single pass, and its results
// (none, one or two words) enter a four-word result queue; the first result is
// offered once the byte has passed the input register and been written into the
// queue. Input is stalled only while the queue holds more than two words, so
// with the result side free a byte goes in every cycle; a byte that yields two
// results occupies the output for both of its words.
// After a stop at score end all bytes are taken and dropped until reset.
`default_nettype none

module mus_event_stream_decoder_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [7:0]                             stream_byte,
    input  wire logic [6:0]                             fade_level,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [3:0]                                  event_kind,
    output logic [mesd_pkg::CH_BITS-1:0]                channel,
    output logic [7:0]                                  number,
    output logic [7:0]                                  value,
    output logic [mesd_pkg::DELAY_BITS-1:0]             delay_ticks,
    output logic                                        is_last,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mesd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [mesd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import mesd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic [6:0] fade_reg;
    logic [6:0] master_reg;
    logic       loop_reg;
    logic       room;
    logic       go;
    push_t      push;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign go        = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= stream_byte;
            fade_reg <= fade_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= MASTER_VOLUME_RESET;
            loop_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MASTER_VOLUME: master_reg <= cfg_data[6:0];
                CFG_LOOP_ENABLE:   loop_reg   <= cfg_data[0];
                default:           master_reg <= master_reg;
            endcase
        end
    end

    mesd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .byte_in (byte_reg),
        .fade    (fade_reg),
        .master  (master_reg),
        .loop_en (loop_reg),
        .push    (push)
    );

    mesd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign event_kind  = head.kind;
    assign channel     = head.channel;
    assign number      = head.number;
    assign value       = head.value;
    assign delay_ticks = head.ticks;
    assign is_last     = head.last;

endmodule

`default_nettype wire

// ----- rtl/mesd_checker.sv -----
// ============================================================================
// mesd_checker
// Port-level checks of the decoder core, bound to the top level.
// ============================================================================
`default_nettype none

module mesd_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_stall,
    input  wire logic [3:0]                             event_kind,
    input  wire logic [mesd_pkg::CH_BITS-1:0]           channel,
    input  wire logic [7:0]                             number,
    input  wire logic [7:0]                             value,
    input  wire logic [mesd_pkg::DELAY_BITS-1:0]        delay_ticks,
    input  wire logic                                   is_last
);
    import mesd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_ticks_only_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_DELAY |-> delay_ticks == '0)
        else $error("nonzero delay on a non-delay word");

    a_delay_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_DELAY |-> channel == '0 && number == 8'd0
                                                  && value == 8'd0 && is_last)
        else $error("delay word carries event fields");

    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !is_last |=> out_valid && is_last
                                                && event_kind == KIND_CTRL
                                                && number == CTRL_VOLUME)
        else $error("notes off not followed by restored volume");

endmodule

bind mus_event_stream_decoder_core mesd_checker u_mesd_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the music score event stream decoder.
// ============================================================================
// Score bytes go in through the valid/stall channel with random gaps, and
// results come out through a second channel with random stalls. A scoreboard
// class keeps its own copy of the parse state, the per-channel velocities and
// the two registers. It works out the events that each accepted byte should
// give and checks every accepted result word against the oldest one waiting.
// A short directed opening covers the corner cases. Random phases then play
// mostly well-formed events under several register settings. The run ends
// with a stop at score end followed by bytes that must be dropped.

import mesd_pkg::*;

class score_event_checker;
    logic [6:0]            master_vol;
    logic                  loop_on;
    logic [3:0]            phase;
    logic [3:0]            cur_chan;
    logic [2:0]            cur_type;
    logic [7:0]            cur_number;
    logic                  delay_pending;
    logic [DELAY_BITS-1:0] ticks_acc;
    logic [7:0]            vel_mem [CHANNEL_COUNT];
    logic                  halted;
    result_t               waiting [$];
    int                    mismatches;
    int                    checked;
    int                    per_kind [9];

    function new();
        master_vol    = MASTER_VOLUME_RESET;
        loop_on       = 1'b0;
        phase         = PH_EVENT;
        cur_chan      = '0;
        cur_type      = '0;
        cur_number    = '0;
        delay_pending = 1'b0;
        ticks_acc     = '0;
        halted        = 1'b0;
        mismatches    = 0;
        checked       = 0;
        foreach (vel_mem[i])
        begin
            vel_mem[i] = '0;
        end
        foreach (per_kind[i])
        begin
            per_kind[i] = 0;
        end
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_MASTER_VOLUME)
        begin
            master_vol = data[6:0];
        end
        else if (idx == CFG_LOOP_ENABLE)
        begin
            loop_on = data[0];
        end
    endfunction

    function logic [7:0] limit_volume(logic [7:0] v, logic [6:0] fade);
        logic [7:0] r;
        r = v;
        if (r > {1'b0, master_vol})
        begin
            r = {1'b0, master_vol};
        end
        if (r > {1'b0, fade})
        begin
            r = {1'b0, fade};
        end
        return r;
    endfunction

    function void queue_event(logic [3:0] kind, logic [3:0] chan, logic [7:0] num,
                              logic [7:0] val, logic [DELAY_BITS-1:0] ticks, logic last);
        result_t r;
        r.kind    = kind;
        r.channel = chan;
        r.number  = num;
        r.value   = val;
        r.ticks   = ticks;
        r.last    = last;
        waiting.push_back(r);
    endfunction

    function void close_event();
        if (delay_pending)
        begin
            ticks_acc = '0;
            phase     = PH_DELAY;
        end
        else
        begin
            phase = PH_EVENT;
        end
    endfunction

    function void note_byte(logic [7:0] b, logic [6:0] fade);
        logic [3:0]  ch;
        logic [63:0] wide;
        ch = cur_chan;
        if (halted)
        begin
            return;
        end
        case (phase)
            PH_EVENT:
            begin
                cur_chan      = b[3:0];
                cur_type      = b[6:4];
                delay_pending = b[7];
                case (cur_type)
                    TYPE_KEY_OFF:  phase = PH_KEY_OFF;
                    TYPE_KEY_ON:   phase = PH_KEY_ON;
                    TYPE_BEND:     phase = PH_BEND;
                    TYPE_SYS_CTRL: phase = PH_SYS_CTRL;
                    TYPE_CTRL:     phase = PH_CTRL_NUM;
                    TYPE_SCORE_END:
                    begin
                        if (loop_on)
                        begin
                            queue_event(KIND_LOOP, b[3:0], '0, '0, '0, 1'b1);
                            close_event();
                        end
                        else
                        begin
                            queue_event(KIND_STOP, b[3:0], '0, '0, '0, 1'b1);
                            halted = 1'b1;
                            phase  = PH_EVENT;
                        end
                    end
                    default: close_event();
                endcase
            end
            PH_KEY_OFF:
            begin
                queue_event(KIND_KEY_OFF, ch, {1'b0, b[6:0]}, '0, '0, 1'b1);
                close_event();
            end
            PH_KEY_ON:
            begin
                if (b[7])
                begin
                    cur_number = {1'b0, b[6:0]};
                    phase      = PH_VELOCITY;
                end
                else
                begin
                    queue_event(KIND_KEY_ON, ch, b, vel_mem[ch], '0, 1'b1);
                    close_event();
                end
            end
            PH_VELOCITY:
            begin
                vel_mem[ch] = b;
                queue_event(KIND_KEY_ON, ch, cur_number, b, '0, 1'b1);
                close_event();
            end
            PH_BEND:
            begin
                queue_event(KIND_BEND, ch, '0, b, '0, 1'b1);
                close_event();
            end
            PH_SYS_CTRL:
            begin
                queue_event(KIND_CTRL, ch, b, '0, '0, 1'b1);
                close_event();
            end
            PH_CTRL_NUM:
            begin
                cur_number = b;
                phase      = PH_CTRL_VAL;
            end
            PH_CTRL_VAL:
            begin
                case (cur_number)
                    CTRL_PROGRAM: queue_event(KIND_PROGRAM, ch, b, '0, '0, 1'b1);
                    CTRL_VOLUME:
                        queue_event(KIND_CTRL, ch, CTRL_VOLUME, limit_volume(b, fade), '0, 1'b1);
                    CTRL_PAN:     queue_event(KIND_CTRL, ch, CTRL_PAN, b, '0, 1'b1);
                    CTRL_NOTES_OFF, CTRL_SOUND_OFF:
                        queue_event(KIND_NOTES_OFF, ch, cur_number, b, '0, 1'b1);
                    CTRL_RESTORE:
                    begin
                        queue_event(KIND_NOTES_OFF, ch, CTRL_RESTORE, b, '0, 1'b0);
                        queue_event(KIND_CTRL, ch, CTRL_VOLUME,
                                    limit_volume(vel_mem[ch], fade), '0, 1'b1);
                    end
                    default: ;
                endcase
                close_event();
            end
            PH_DELAY:
            begin
                wide = 64'(ticks_acc);
                wide = (wide << 7) + 64'(b[6:0]);
                if (wide > 64'(DELAY_MAX))
                begin
                    wide = 64'(DELAY_MAX);
                end
                ticks_acc = wide[DELAY_BITS-1:0];
                if (!b[7])
                begin
                    queue_event(KIND_DELAY, '0, '0, '0, ticks_acc, 1'b1);
                    phase = PH_EVENT;
                end
            end
            default: phase = PH_EVENT;
        endcase
    endfunction

    function void note_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: want kind %0d ch %0d num %0d val %0d ticks %0d last %0d",
                     what, want.kind, want.channel, want.number, want.value,
                     want.ticks, want.last);
            $display("    got  kind %0d ch %0d num %0d val %0d ticks %0d last %0d",
                     got.kind, got.channel, got.number, got.value, got.ticks, got.last);
        end
    endfunction

    function void check_event(result_t got);
        result_t want;
        if (waiting.size() == 0)
        begin
            note_mismatch("unexpected word", '0, got);
            return;
        end
        want = waiting.pop_front();
        checked++;
        if (got.kind !== want.kind || got.channel !== want.channel ||
            got.number !== want.number || got.value !== want.value ||
            got.ticks !== want.ticks || got.last !== want.last)
        begin
            note_mismatch("word mismatch", want, got);
        end
        else
        begin
            per_kind[want.kind]++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    QUIET_CYCLES = 12;
    localparam int    PHASES       = 8;
    localparam int    PHASE_BYTES  = 125;
    localparam realtime RUN_LIMIT  = 1ms;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                stream_byte;
    logic [6:0]                fade_level;
    logic                      out_valid;
    logic                      out_stall;
    logic [3:0]                event_kind;
    logic [CH_BITS-1:0]        channel;
    logic [7:0]                number;
    logic [7:0]                value;
    logic [DELAY_BITS-1:0]     delay_ticks;
    logic                      is_last;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    score_event_checker sb;
    int                 in_mode;
    int                 out_mode;
    int                 bytes_fed;
    int                 settings_used;
    bit                 stop_ok;

    mus_event_stream_decoder_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .fade_level  (fade_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .channel     (channel),
        .number      (number),
        .value       (value),
        .delay_ticks (delay_ticks),
        .is_last     (is_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // mode 0: never waits, 1: waits now and then, 2: draws a random wait for every word
    function automatic int draw_wait(input int mode);
        if (mode == 0)
        begin
            return 0;
        end
        if (mode == 1 && $urandom_range(0, 3) != 0)
        begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [6:0] rand_fade();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic [6:0] f);
        logic [7:0] word;
        int         gap;
        word = b;
        gap  = draw_wait(in_mode);
        // keep playback alive: a score end under loop off becomes a type 7 event
        if (!stop_ok && !sb.loop_on && !sb.halted && sb.phase == PH_EVENT &&
            word[6:4] == TYPE_SCORE_END)
        begin
            word[4] = 1'b1;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= word;
        fade_level  <= f;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_byte(word, f);
        bytes_fed++;
        @(negedge clk);
    endtask

    task automatic set_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.waiting.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // feed terminating bytes until the parser waits for an event byte
    task automatic settle_parser();
        while (sb.phase != PH_EVENT)
        begin
            push_byte(8'($urandom_range(0, 127)), rand_fade());
        end
    endtask

    task automatic play_event(input logic [2:0] typ, input logic with_delay);
        logic [7:0] b;
        int         len;
        push_byte({with_delay, typ, 4'($urandom_range(0, 15))}, rand_fade());
        case (typ)
            TYPE_KEY_OFF, TYPE_BEND, TYPE_SYS_CTRL:
                push_byte(8'($urandom), rand_fade());
            TYPE_KEY_ON:
            begin
                b = 8'($urandom);
                push_byte(b, rand_fade());
                if (b[7])
                begin
                    push_byte(8'($urandom), rand_fade());
                end
            end
            TYPE_CTRL:
            begin
                case ($urandom_range(0, 7))
                    0:       b = CTRL_PROGRAM;
                    1:       b = CTRL_VOLUME;
                    2:       b = CTRL_PAN;
                    3:       b = CTRL_NOTES_OFF;
                    4:       b = CTRL_SOUND_OFF;
                    5:       b = CTRL_RESTORE;
                    default: b = 8'($urandom);
                endcase
                push_byte(b, rand_fade());
                push_byte(8'($urandom), rand_fade());
            end
            default: ;
        endcase
        if (sb.phase == PH_DELAY)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = 1;
                4, 5, 6:    len = 2;
                7:          len = 3;
                8:          len = 4;
                default:    len = 5;
            endcase
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       b[6:0] = 7'd0;
                    1:       b[6:0] = 7'd127;
                    default: b[6:0] = 7'($urandom_range(0, 127));
                endcase
                b[7] = (i != len - 1);
                push_byte(b, rand_fade());
            end
        end
    endtask

    initial
    begin : result_side
        result_t got;
        int      hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = draw_wait(out_mode);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            got.kind    = event_kind;
            got.channel = channel;
            got.number  = number;
            got.value   = value;
            got.ticks   = delay_ticks;
            got.last    = is_last;
            sb.check_event(got);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int         goal;
        int         next_mix;
        int         fed_before_stop;
        logic [6:0] vol;
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        stream_byte   = '0;
        fade_level    = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_mode       = 2;
        out_mode      = 1;
        bytes_fed     = 0;
        settings_used = 1;
        stop_ok       = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening under reset register values
        push_byte(8'h00, 7'd127);   // key off, key bit 7 dropped
        push_byte(8'hFF, 7'd127);
        push_byte(8'h1F, 7'd127);   // key on with velocity byte
        push_byte(8'h85, 7'd127);
        push_byte(8'hFF, 7'd127);
        push_byte(8'h9F, 7'd0);     // key on with stored velocity, zero delay
        push_byte(8'h00, 7'd0);
        push_byte(8'h00, 7'd0);
        push_byte(8'h20, 7'd64);    // bend
        push_byte(8'hFF, 7'd64);
        push_byte(8'h3A, 7'd1);     // system controller
        push_byte(8'h80, 7'd1);
        push_byte(8'h4F, 7'd5);     // restore: notes off then clamped volume
        push_byte(CTRL_RESTORE, 7'd5);
        push_byte(8'h00, 7'd5);
        push_byte(8'h41, 7'd127);   // volume clamped to master
        push_byte(CTRL_VOLUME, 7'd127);
        push_byte(8'hFF, 7'd127);
        push_byte(8'h43, 7'd33);    // unknown controller, no word
        push_byte(8'h63, 7'd33);
        push_byte(8'h11, 7'd33);
        push_byte(8'hD0, 7'd90);    // type 5 with delay that saturates
        repeat (4) push_byte(8'hFF, 7'd90);
        push_byte(8'h7F, 7'd90);
        push_byte(8'h70, 7'd12);    // type 7, nothing
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       vol = 7'd0;
                1:       vol = 7'd127;
                2:       vol = 7'd1;
                default: vol = 7'($urandom_range(0, 127));
            endcase
            set_register(CFG_MASTER_VOLUME, {1'($urandom_range(0, 1)), vol});
            set_register(CFG_LOOP_ENABLE, {7'($urandom), ~p[0]});
            settings_used++;
            if (p == 0)
            begin
                settle_parser();
                push_byte(8'hE3, rand_fade());   // score end with loop, then a delay
                push_byte(8'h05, rand_fade());
            end
            in_mode  = $urandom_range(0, 2);
            out_mode = $urandom_range(0, 2);
            goal     = bytes_fed + PHASE_BYTES;
            next_mix = bytes_fed + 60;
            while (bytes_fed < goal)
            begin
                if (bytes_fed >= next_mix)
                begin
                    in_mode  = $urandom_range(0, 2);
                    out_mode = $urandom_range(0, 2);
                    next_mix = bytes_fed + 60;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    push_byte(8'($urandom), rand_fade());
                end
                else
                begin
                    play_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                end
            end
            drain_results();
        end

        // loop is off now: score end stops, delay flag ignored, rest dropped
        settle_parser();
        stop_ok = 1'b1;
        push_byte(8'hE6, rand_fade());
        fed_before_stop = bytes_fed;
        repeat (20) push_byte(8'($urandom), rand_fade());
        drain_results();

        $display("fed %0d score bytes under %0d register settings, then %0d after stop",
                 fed_before_stop, settings_used, bytes_fed - fed_before_stop);
        $display("matched %0d words: koff %0d kon %0d bend %0d ctrl %0d prog %0d",
                 sb.checked, sb.per_kind[KIND_KEY_OFF], sb.per_kind[KIND_KEY_ON],
                 sb.per_kind[KIND_BEND], sb.per_kind[KIND_CTRL], sb.per_kind[KIND_PROGRAM]);
        $display("    notes off %0d loop %0d stop %0d delay %0d, mismatches %0d",
                 sb.per_kind[KIND_NOTES_OFF], sb.per_kind[KIND_LOOP],
                 sb.per_kind[KIND_STOP], sb.per_kind[KIND_DELAY], sb.mismatches);
        if (sb.mismatches == 0 && sb.waiting.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
